### rtl/otl_pkg.sv
// ----------------------------------------------------------------------------
// Offside layout token inserter package
// Shared constants, codes and types of the layout token inserter.
// ----------------------------------------------------------------------------
package otl_pkg;

    localparam int DEF_FRAME_DEPTH  = 16;
    localparam int DEF_TRIVIA_DEPTH = 16;
    localparam int MAX_RESULTS      = 50;

    localparam int KIND_W   = 8;
    localparam int OFS_W    = 32;
    localparam int COL_W    = 16;
    localparam int STR_W    = 32;
    localparam int CLS_W    = 3;
    localparam int IN_DATA_W  = 120;
    localparam int IN_USER_W  = 5;
    localparam int OUT_DATA_W = 104;
    localparam int OUT_USER_W = 2;
    localparam int APB_AW   = 4;
    localparam int FRAME_W  = COL_W + 2;
    localparam int TRIVIA_W = KIND_W + OFS_W + OFS_W + STR_W;

    typedef enum logic [CLS_W-1:0] {
        CLS_ORDINARY = 3'd0,
        CLS_NEWLINE  = 3'd1,
        CLS_TRIVIA   = 3'd2,
        CLS_OPEN     = 3'd3,
        CLS_CLOSE    = 3'd4,
        CLS_EOF      = 3'd5,
        CLS_ERROR    = 3'd6,
        CLS_SEMI     = 3'd7
    } token_class_t;

    typedef enum logic [1:0] {
        FK_ROOT   = 2'd0,
        FK_LAYOUT = 2'd1,
        FK_BRACE  = 2'd2,
        FK_UNUSED = 2'd3
    } frame_kind_t;

    typedef enum logic [1:0] {
        REG_OPEN_KIND  = 2'd0,
        REG_CLOSE_KIND = 2'd1,
        REG_SEMI_KIND  = 2'd2,
        REG_NO_STRING  = 2'd3
    } reg_index_t;

    typedef enum logic {
        PASS_COUNT = 1'b0,
        PASS_EMIT  = 1'b1
    } pass_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_TRIV,
        ST_INIT,
        ST_EVAL,
        ST_OPEN,
        ST_DSEMI,
        ST_DCLOSE,
        ST_POP_RD,
        ST_POP_WB,
        ST_CL_LOOP,
        ST_CL_CLOSE,
        ST_CL_SEMI,
        ST_EOF_SEMI,
        ST_EOF_LOOP,
        ST_EOF_CLOSE,
        ST_EOF_SEMI2,
        ST_SIB,
        ST_FL_RD,
        ST_FL_EM,
        ST_TOK,
        ST_POST,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic [KIND_W-1:0] open_kind;
        logic [KIND_W-1:0] close_kind;
        logic [KIND_W-1:0] semi_kind;
        logic [STR_W-1:0]  no_string;
    } cfg_t;

endpackage

### rtl/otl_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data held between reads.
// ----------------------------------------------------------------------------
module otl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/otl_cfg.sv
// ----------------------------------------------------------------------------
// Layout inserter register block
// APB-style register file for virtual token kinds and the synthetic string id.
// ----------------------------------------------------------------------------
module otl_cfg (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [otl_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output otl_pkg::cfg_t             cfg
);
    import otl_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    reg_index_t idx;
    logic       wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = reg_index_t'(paddr[3:2]);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            unique case (idx)
                REG_OPEN_KIND:  cfg_next.open_kind  = pwdata[KIND_W-1:0];
                REG_CLOSE_KIND: cfg_next.close_kind = pwdata[KIND_W-1:0];
                REG_SEMI_KIND:  cfg_next.semi_kind  = pwdata[KIND_W-1:0];
                REG_NO_STRING:  cfg_next.no_string  = pwdata;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_OPEN_KIND:  prdata = {24'd0, cfg_reg.open_kind};
            REG_CLOSE_KIND: prdata = {24'd0, cfg_reg.close_kind};
            REG_SEMI_KIND:  prdata = {24'd0, cfg_reg.semi_kind};
            REG_NO_STRING:  prdata = cfg_reg.no_string;
            default:        prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/otl_core.sv
// ----------------------------------------------------------------------------
// Layout inserter sequencer
// Frame stack and trivia buffer in RAM; each token but trivia and newlines
// runs a counting pass, then an emitting pass through the same micro-sequence.
// ----------------------------------------------------------------------------
module otl_core #(
    parameter int FRAME_DEPTH  = otl_pkg::DEF_FRAME_DEPTH,
    parameter int TRIVIA_DEPTH = otl_pkg::DEF_TRIVIA_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  otl_pkg::cfg_t                 cfg,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [otl_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic [otl_pkg::IN_USER_W-1:0]  s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [otl_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic [otl_pkg::OUT_USER_W-1:0] m_tuser,
    output logic                          m_tlast
);
    import otl_pkg::*;

    localparam int FA  = $clog2(FRAME_DEPTH);
    localparam int TA  = (TRIVIA_DEPTH > 1) ? $clog2(TRIVIA_DEPTH) : 1;
    localparam int FCW = $clog2(FRAME_DEPTH + 1);
    localparam int TCW = $clog2(TRIVIA_DEPTH + 1);
    localparam int NW  = $clog2(MAX_RESULTS + 1);

    state_t state_reg, state_next, ret_reg, ret_next;
    pass_t  pass_reg, pass_next;

    logic [KIND_W-1:0] tk_kind_reg, tk_kind_next;
    token_class_t      tk_cls_reg, tk_cls_next;
    logic              tk_sc_reg, tk_sc_next, tk_ec_reg, tk_ec_next;
    logic [OFS_W-1:0]  tk_st_reg, tk_st_next, tk_en_reg, tk_en_next;
    logic [COL_W-1:0]  tk_col_reg, tk_col_next;
    logic [STR_W-1:0]  tk_str_reg, tk_str_next;

    logic [FCW-1:0]    fc_reg, fc_next, snap_fc_reg, snap_fc_next;
    logic [COL_W-1:0]  ci_reg, ci_next, snap_ci_reg, snap_ci_next;
    frame_kind_t       ck_reg, ck_next, snap_ck_reg, snap_ck_next;
    logic              pt_reg, pt_next, snap_pt_reg, snap_pt_next;
    logic              pe_reg, pe_next, snap_pe_reg, snap_pe_next;
    logic [OFS_W-1:0]  poff_reg, poff_next, snap_poff_reg, snap_poff_next;
    logic              nl_reg, nl_next, snap_nl_reg, snap_nl_next;
    logic [TCW-1:0]    tc_reg, tc_next, snap_tc_reg, snap_tc_next;
    logic              std_reg, std_next, snap_std_reg, snap_std_next;
    logic              ovf_reg, ovf_next, snap_ovf_reg, snap_ovf_next;

    logic [TCW-1:0]    ti_reg, ti_next;
    logic [NW-1:0]     n_reg, n_next, ntot_reg, ntot_next;
    logic              ovf_fin_reg, ovf_fin_next;

    logic               fwd_v_reg, fwd_v_next;
    logic [FCW-1:0]     fwd_idx_reg, fwd_idx_next;
    logic [FRAME_W-1:0] fwd_data_reg, fwd_data_next;

    logic                  m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;
    logic [OUT_USER_W-1:0] m_user_reg, m_user_next;
    logic                  m_last_reg, m_last_next;

    logic               fr_we, fr_re, tv_we, tv_re;
    logic [FA-1:0]      fr_waddr, fr_raddr;
    logic [TA-1:0]      tv_waddr, tv_raddr;
    logic [FRAME_W-1:0] fr_wdata, fr_rdata, pop_data;
    logic [TRIVIA_W-1:0] tv_wdata, tv_rdata;

    logic cont, open_c, open_ok, dedent_c, sib_c, frame_full;
    logic emit_st, can_emit, out_free, go, load;
    logic [FCW-1:0] fc_dec;
    logic [KIND_W-1:0] e_kind;
    logic [OFS_W-1:0]  e_st, e_en;
    logic [STR_W-1:0]  e_str;
    logic              e_syn;

    assign s_tready   = (state_reg == ST_IDLE);
    assign fc_dec     = fc_reg - 1'b1;
    assign frame_full = (fc_reg >= FCW'(FRAME_DEPTH));
    assign cont       = tk_sc_reg || pe_reg;
    assign open_c     = nl_reg && (tk_col_reg > ci_reg) && !cont;
    assign open_ok    = open_c && !frame_full;
    assign dedent_c   = nl_reg && (tk_col_reg < ci_reg) && (fc_reg != '0) &&
                        !(tk_cls_reg == CLS_CLOSE && ck_reg == FK_BRACE);
    assign sib_c      = nl_reg && (tk_col_reg == ci_reg) && !cont && !pt_reg;
    assign pop_data   = (fwd_v_reg && fwd_idx_reg == fc_dec) ? fwd_data_reg : fr_rdata;

    assign emit_st = (state_reg == ST_OPEN) || (state_reg == ST_DSEMI) ||
                     (state_reg == ST_DCLOSE) || (state_reg == ST_CL_CLOSE) ||
                     (state_reg == ST_CL_SEMI) || (state_reg == ST_EOF_SEMI) ||
                     (state_reg == ST_EOF_CLOSE) || (state_reg == ST_EOF_SEMI2) ||
                     (state_reg == ST_SIB) || (state_reg == ST_FL_EM) ||
                     (state_reg == ST_TOK);
    assign can_emit = (n_reg < NW'(MAX_RESULTS));
    assign out_free = !m_valid_reg || m_tready;
    assign go       = !emit_st || (pass_reg == PASS_COUNT) || !can_emit || out_free;
    assign load     = emit_st && (pass_reg == PASS_EMIT) && can_emit && out_free;

    always_comb
    begin
        e_kind = tk_kind_reg;
        e_st   = tk_st_reg;
        e_en   = tk_en_reg;
        e_str  = tk_str_reg;
        e_syn  = 1'b0;
        priority case (state_reg)
            ST_OPEN:
            begin
                e_kind = cfg.open_kind;
                e_syn  = 1'b1;
            end
            ST_DCLOSE, ST_CL_CLOSE, ST_EOF_CLOSE:
            begin
                e_kind = cfg.close_kind;
                e_syn  = 1'b1;
            end
            ST_DSEMI, ST_CL_SEMI, ST_EOF_SEMI, ST_EOF_SEMI2, ST_SIB:
            begin
                e_kind = cfg.semi_kind;
                e_syn  = 1'b1;
            end
            ST_FL_EM:
            begin
                {e_kind, e_st, e_en, e_str} = tv_rdata;
            end
            default:
            begin
                e_syn = 1'b0;
            end
        endcase
        if (e_syn)
        begin
            e_st  = poff_reg;
            e_en  = poff_reg;
            e_str = cfg.no_string;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser[2:0] == CLS_NEWLINE || s_tuser[2:0] == CLS_TRIVIA)
                    begin
                        state_next = ST_TRIV;
                    end
                    else
                    begin
                        state_next = ST_INIT;
                    end
                end
            end
            ST_TRIV: state_next = ST_IDLE;
            ST_INIT:
            begin
                if (tk_cls_reg == CLS_EOF)
                begin
                    state_next = (pass_reg == PASS_COUNT ? pt_reg : snap_pt_reg) ?
                                 ST_EOF_LOOP : ST_EOF_SEMI;
                end
                else if (tk_cls_reg == CLS_ERROR)
                begin
                    state_next = ST_FL_RD;
                end
                else
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (open_ok)
                begin
                    state_next = ST_OPEN;
                end
                else if (dedent_c)
                begin
                    state_next = pt_reg ? ST_DCLOSE : ST_DSEMI;
                end
                else if (tk_cls_reg == CLS_OPEN)
                begin
                    state_next = ST_FL_RD;
                end
                else if (tk_cls_reg == CLS_CLOSE)
                begin
                    state_next = ST_CL_LOOP;
                end
                else
                begin
                    state_next = sib_c ? ST_SIB : ST_FL_RD;
                end
            end
            ST_OPEN:      if (go) state_next = ST_EVAL;
            ST_DSEMI:     if (go) state_next = ST_DCLOSE;
            ST_DCLOSE:    if (go) state_next = ST_POP_RD;
            ST_POP_RD:    state_next = ST_POP_WB;
            ST_POP_WB:    state_next = ret_reg;
            ST_CL_LOOP:
            begin
                if (ck_reg == FK_LAYOUT && fc_reg != '0)
                begin
                    state_next = ST_CL_CLOSE;
                end
                else
                begin
                    state_next = pt_reg ? ST_FL_RD : ST_CL_SEMI;
                end
            end
            ST_CL_CLOSE:  if (go) state_next = ST_POP_RD;
            ST_CL_SEMI:   if (go) state_next = ST_FL_RD;
            ST_EOF_SEMI:  if (go) state_next = ST_EOF_LOOP;
            ST_EOF_LOOP:  state_next = (fc_reg != '0) ? ST_EOF_CLOSE : ST_FL_RD;
            ST_EOF_CLOSE: if (go) state_next = ST_EOF_SEMI2;
            ST_EOF_SEMI2: if (go) state_next = ST_POP_RD;
            ST_SIB:       if (go) state_next = ST_FL_RD;
            ST_FL_RD:     state_next = (ti_reg < tc_reg) ? ST_FL_EM : ST_TOK;
            ST_FL_EM:     if (go) state_next = ST_FL_RD;
            ST_TOK:       if (go) state_next = ST_POST;
            ST_POST:
            begin
                if (tk_cls_reg == CLS_CLOSE && fc_reg != '0)
                begin
                    state_next = ST_POP_RD;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:       state_next = (pass_reg == PASS_COUNT) ? ST_INIT : ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        ret_next  = ret_reg;
        pass_next = pass_reg;
        tk_kind_next = tk_kind_reg;
        tk_cls_next  = tk_cls_reg;
        tk_sc_next   = tk_sc_reg;
        tk_ec_next   = tk_ec_reg;
        tk_st_next   = tk_st_reg;
        tk_en_next   = tk_en_reg;
        tk_col_next  = tk_col_reg;
        tk_str_next  = tk_str_reg;
        fc_next   = fc_reg;
        ci_next   = ci_reg;
        ck_next   = ck_reg;
        pt_next   = pt_reg;
        pe_next   = pe_reg;
        poff_next = poff_reg;
        nl_next   = nl_reg;
        tc_next   = tc_reg;
        std_next  = std_reg;
        ovf_next  = ovf_reg;
        snap_fc_next   = snap_fc_reg;
        snap_ci_next   = snap_ci_reg;
        snap_ck_next   = snap_ck_reg;
        snap_pt_next   = snap_pt_reg;
        snap_pe_next   = snap_pe_reg;
        snap_poff_next = snap_poff_reg;
        snap_nl_next   = snap_nl_reg;
        snap_tc_next   = snap_tc_reg;
        snap_std_next  = snap_std_reg;
        snap_ovf_next  = snap_ovf_reg;
        ti_next      = ti_reg;
        n_next       = n_reg;
        ntot_next    = ntot_reg;
        ovf_fin_next = ovf_fin_reg;
        fwd_v_next    = fwd_v_reg;
        fwd_idx_next  = fwd_idx_reg;
        fwd_data_next = fwd_data_reg;
        fr_we    = 1'b0;
        fr_waddr = fc_reg[FA-1:0];
        fr_wdata = {ck_reg, ci_reg};
        fr_re    = 1'b0;
        fr_raddr = fc_dec[FA-1:0];
        tv_we    = 1'b0;
        tv_waddr = tc_reg[TA-1:0];
        tv_wdata = {tk_kind_reg, tk_st_reg, tk_en_reg, tk_str_reg};
        tv_re    = 1'b0;
        tv_raddr = ti_reg[TA-1:0];
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        m_last_next  = m_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    tk_kind_next = s_tdata[7:0];
                    tk_st_next   = s_tdata[39:8];
                    tk_en_next   = s_tdata[71:40];
                    tk_col_next  = s_tdata[87:72];
                    tk_str_next  = s_tdata[119:88];
                    tk_cls_next  = token_class_t'(s_tuser[2:0]);
                    tk_sc_next   = s_tuser[3];
                    tk_ec_next   = s_tuser[4];
                    pass_next    = PASS_COUNT;
                end
            end
            ST_TRIV:
            begin
                if (!std_reg)
                begin
                    poff_next = tk_st_reg;
                    std_next  = 1'b1;
                end
                if (tk_cls_reg == CLS_NEWLINE)
                begin
                    nl_next = 1'b1;
                end
                if (tc_reg < TCW'(TRIVIA_DEPTH))
                begin
                    tv_we   = 1'b1;
                    tc_next = tc_reg + 1'b1;
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            ST_INIT:
            begin
                if (pass_reg == PASS_COUNT)
                begin
                    snap_fc_next   = fc_reg;
                    snap_ci_next   = ci_reg;
                    snap_ck_next   = ck_reg;
                    snap_pt_next   = pt_reg;
                    snap_pe_next   = pe_reg;
                    snap_poff_next = poff_reg;
                    snap_nl_next   = nl_reg;
                    snap_tc_next   = tc_reg;
                    snap_std_next  = std_reg;
                    snap_ovf_next  = ovf_reg;
                end
                else
                begin
                    fc_next   = snap_fc_reg;
                    ci_next   = snap_ci_reg;
                    ck_next   = snap_ck_reg;
                    pt_next   = snap_pt_reg;
                    pe_next   = snap_pe_reg;
                    poff_next = snap_poff_reg;
                    nl_next   = snap_nl_reg;
                    tc_next   = snap_tc_reg;
                    std_next  = snap_std_reg;
                    ovf_next  = snap_ovf_reg;
                end
                if (!std_next)
                begin
                    poff_next = tk_st_reg;
                    std_next  = 1'b1;
                end
                if (ck_next == FK_BRACE && ci_next == '0)
                begin
                    ci_next = tk_col_reg;
                end
                ti_next    = '0;
                n_next     = '0;
                fwd_v_next = 1'b0;
            end
            ST_EVAL:
            begin
                if (open_c && frame_full)
                begin
                    ovf_next = 1'b1;
                end
            end
            ST_OPEN:
            begin
                if (go)
                begin
                    fr_we         = (pass_reg == PASS_EMIT);
                    fwd_v_next    = 1'b1;
                    fwd_idx_next  = fc_reg;
                    fwd_data_next = {ck_reg, ci_reg};
                    fc_next = fc_reg + 1'b1;
                    ci_next = tk_col_reg;
                    ck_next = FK_LAYOUT;
                    pt_next = 1'b1;
                    pe_next = 1'b1;
                    nl_next = 1'b0;
                end
            end
            ST_DCLOSE:
            begin
                if (go)
                begin
                    pt_next  = 1'b0;
                    pe_next  = 1'b0;
                    ret_next = ST_EVAL;
                end
            end
            ST_CL_CLOSE:
            begin
                if (go)
                begin
                    ret_next = ST_CL_LOOP;
                end
            end
            ST_EOF_SEMI2:
            begin
                if (go)
                begin
                    ret_next = ST_EOF_LOOP;
                end
            end
            ST_POP_RD:
            begin
                fr_re = 1'b1;
            end
            ST_POP_WB:
            begin
                ci_next = pop_data[COL_W-1:0];
                ck_next = frame_kind_t'(pop_data[FRAME_W-1:COL_W]);
                fc_next = fc_dec;
            end
            ST_FL_RD:
            begin
                if (ti_reg < tc_reg)
                begin
                    tv_re = 1'b1;
                end
                else
                begin
                    tc_next = '0;
                end
            end
            ST_FL_EM:
            begin
                if (go)
                begin
                    ti_next = ti_reg + 1'b1;
                end
            end
            ST_POST:
            begin
                ret_next = ST_FIN;
                if (tk_cls_reg == CLS_OPEN)
                begin
                    if (!frame_full)
                    begin
                        fr_we   = (pass_reg == PASS_EMIT);
                        fc_next = fc_reg + 1'b1;
                        ci_next = '0;
                        ck_next = FK_BRACE;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
            ST_FIN:
            begin
                if (tk_cls_reg != CLS_EOF)
                begin
                    pt_next   = (tk_cls_reg == CLS_OPEN) || (tk_cls_reg == CLS_SEMI);
                    pe_next   = tk_ec_reg;
                    poff_next = tk_en_reg;
                    nl_next   = 1'b0;
                end
                if (pass_reg == PASS_COUNT)
                begin
                    ntot_next    = n_reg;
                    ovf_fin_next = ovf_reg;
                    pass_next    = PASS_EMIT;
                end
                else if (tk_cls_reg == CLS_EOF)
                begin
                    fc_next   = '0;
                    ci_next   = COL_W'(1);
                    ck_next   = FK_ROOT;
                    pt_next   = 1'b1;
                    pe_next   = 1'b0;
                    poff_next = '0;
                    nl_next   = 1'b0;
                    tc_next   = '0;
                    std_next  = 1'b0;
                    ovf_next  = 1'b0;
                end
            end
            default:
            begin
                ret_next = ret_reg;
            end
        endcase

        if (emit_st && go)
        begin
            if (can_emit)
            begin
                n_next = n_reg + 1'b1;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        if (load)
        begin
            m_valid_next = 1'b1;
            m_data_next  = {e_str, e_en, e_st, e_kind};
            m_user_next  = {ovf_fin_reg, e_syn};
            m_last_next  = (n_reg == ntot_reg - 1'b1);
        end
    end

    otl_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (FRAME_DEPTH)
    ) u_frame_ram (
        .clk   (clk),
        .we    (fr_we),
        .waddr (fr_waddr),
        .wdata (fr_wdata),
        .re    (fr_re),
        .raddr (fr_raddr),
        .rdata (fr_rdata)
    );

    otl_ram #(
        .WIDTH (TRIVIA_W),
        .DEPTH (TRIVIA_DEPTH)
    ) u_trivia_ram (
        .clk   (clk),
        .we    (tv_we),
        .waddr (tv_waddr),
        .wdata (tv_wdata),
        .re    (tv_re),
        .raddr (tv_raddr),
        .rdata (tv_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            ret_reg     <= ST_FIN;
            pass_reg    <= PASS_COUNT;
            fc_reg      <= '0;
            ci_reg      <= COL_W'(1);
            ck_reg      <= FK_ROOT;
            pt_reg      <= 1'b1;
            pe_reg      <= 1'b0;
            poff_reg    <= '0;
            nl_reg      <= 1'b0;
            tc_reg      <= '0;
            std_reg     <= 1'b0;
            ovf_reg     <= 1'b0;
            ti_reg      <= '0;
            n_reg       <= '0;
            ntot_reg    <= '0;
            ovf_fin_reg <= 1'b0;
            fwd_v_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            pass_reg    <= pass_next;
            fc_reg      <= fc_next;
            ci_reg      <= ci_next;
            ck_reg      <= ck_next;
            pt_reg      <= pt_next;
            pe_reg      <= pe_next;
            poff_reg    <= poff_next;
            nl_reg      <= nl_next;
            tc_reg      <= tc_next;
            std_reg     <= std_next;
            ovf_reg     <= ovf_next;
            ti_reg      <= ti_next;
            n_reg       <= n_next;
            ntot_reg    <= ntot_next;
            ovf_fin_reg <= ovf_fin_next;
            fwd_v_reg   <= fwd_v_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tk_kind_reg    <= tk_kind_next;
        tk_cls_reg     <= tk_cls_next;
        tk_sc_reg      <= tk_sc_next;
        tk_ec_reg      <= tk_ec_next;
        tk_st_reg      <= tk_st_next;
        tk_en_reg      <= tk_en_next;
        tk_col_reg     <= tk_col_next;
        tk_str_reg     <= tk_str_next;
        snap_fc_reg    <= snap_fc_next;
        snap_ci_reg    <= snap_ci_next;
        snap_ck_reg    <= snap_ck_next;
        snap_pt_reg    <= snap_pt_next;
        snap_pe_reg    <= snap_pe_next;
        snap_poff_reg  <= snap_poff_next;
        snap_nl_reg    <= snap_nl_next;
        snap_tc_reg    <= snap_tc_next;
        snap_std_reg   <= snap_std_next;
        snap_ovf_reg   <= snap_ovf_next;
        fwd_idx_reg    <= fwd_idx_next;
        fwd_data_reg   <= fwd_data_next;
        m_data_reg     <= m_data_next;
        m_user_reg     <= m_user_next;
        m_last_reg     <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    a_frame_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fc_reg <= FCW'(FRAME_DEPTH))
        else $error("frame count beyond stack depth");

    a_trivia_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tc_reg <= TCW'(TRIVIA_DEPTH))
        else $error("trivia count beyond buffer depth");

    a_emit_in_count: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (n_reg < ntot_reg))
        else $error("emitting pass produced more beats than counted");

    a_write_emit_only: assert property (@(posedge clk) disable iff (!rst_n)
        fr_we |-> (pass_reg == PASS_EMIT))
        else $error("frame stack written during counting pass");

endmodule

### rtl/offside_layout_token_inserter.sv
// ----------------------------------------------------------------------------
// Offside layout token inserter
// Inserts virtual braces and semicolons into a classified token stream.
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+---------------------------------------
//  s_axis   | in  | s_tvalid/tready  | s_tdata, s_tuser (one token)
//  m_axis   | out | m_tvalid/tready  | m_tdata, m_tuser, m_tlast (one token)
//  apb      | in  | psel/penable     | paddr, pwdata, prdata
//
//  A trivia or newline token is buffered in the trivia RAM while it has room.
//  Any other token is accepted, then runs a counting pass and an emitting
//  pass, each covering R results, T buffered trivia read from the trivia RAM
//  and P frames popped from the frame RAM.
//  Reset clears all control state; RAM contents need no clearing.
//  A stalled m_tready holds the emitting pass; input waits until the token
//  in flight is done.
// ----------------------------------------------------------------------------
module offside_layout_token_inserter #(
    parameter int FRAME_DEPTH  = otl_pkg::DEF_FRAME_DEPTH,
    parameter int TRIVIA_DEPTH = otl_pkg::DEF_TRIVIA_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // kind[7:0], start[39:8], end[71:40], column[87:72], string[119:88]
    input  logic [otl_pkg::IN_DATA_W-1:0]  s_tdata,
    // class[2:0], starts_continuation[3], ends_continuation[4]
    input  logic [otl_pkg::IN_USER_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // kind[7:0], start[39:8], end[71:40], string[103:72]
    output logic [otl_pkg::OUT_DATA_W-1:0] m_tdata,
    // is_synthetic[0], overflow[1]
    output logic [otl_pkg::OUT_USER_W-1:0] m_tuser,
    output logic                           m_tlast,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [otl_pkg::APB_AW-1:0]     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import otl_pkg::*;

    cfg_t cfg;

    otl_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    otl_core #(
        .FRAME_DEPTH  (FRAME_DEPTH),
        .TRIVIA_DEPTH (TRIVIA_DEPTH)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
